>>> hw/rtl/ith_pkg.sv
package ith_pkg;

	typedef enum logic [2:0] {
		KIND_ADD    = 3'd0,
		KIND_ADJUST = 3'd1,
		KIND_FIRE   = 3'd2,
		KIND_TICK   = 3'd3,
		KIND_QUERY  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_EXPIRED = 3'd0,
		ST_FIRED   = 3'd1,
		ST_NEXT    = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	localparam int unsigned EXPIRY_W = 32;
	localparam int unsigned TMO_W    = 24;
	localparam int unsigned IDF_W    = 8;

endpackage

>>> hw/rtl/ith_ram.sv
module ith_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/indexed_timer_heap.sv
// Timer queue: binary min-heap of (id, expiry) plus an id-to-slot table, with
// an internal millisecond counter advanced by each tick. A command is taken when
// start is high and busy is low, and busy stays high until it is done. Results
// go out one beat per cycle on valid and cannot be stalled. The receiver must
// take every beat in the cycle it appears, and last marks the final beat of a
// command. Each command passes through the lookup states LOOK and LOOK2 before
// DISPATCH. Sift-up and sift-down then walk the heap a level at a time through
// read, compare and swap states, since the heap RAM has one read port. Each
// expired timer adds the states EXPCHK, EXPCHK2, REM and REM2 plus its sift-down.
// A tick holds each expired beat until the next due check, so it can tell whether
// that beat is the last. After reset the block clears its id table with busy high.
module indexed_timer_heap #(
	parameter int unsigned CAPACITY = 32,
	parameter int unsigned ID_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  timer_id,
	input  logic [23:0] timeout_ms,
	output logic        valid,
	output logic [2:0]  status,
	output logic [7:0]  expired_id,
	output logic [23:0] remaining_ms,
	output logic        none_pending,
	output logic        last
);
	localparam int unsigned SW = (CAPACITY < 2) ? 1 : $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = (ID_COUNT < 2) ? 1 : $clog2(ID_COUNT);
	localparam int unsigned EW = ith_pkg::IDF_W + ith_pkg::EXPIRY_W;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_LOOK2, S_DISPATCH,
		S_SET, S_EXPCHK, S_EXPCHK2, S_REM, S_REM2,
		S_DN_RD, S_DN_C1, S_DN_C2, S_DN_CMP, S_UP_RD, S_UP_P, S_UP_CMP,
		S_SWAP, S_SWAP2
	} state_t;

	state_t state_q, after_swap_q;
	logic [2:0]  kind_q;
	logic [7:0]  id_q;
	logic [23:0] tmo_q;
	logic [31:0] now_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] i_q, c_q, rem_slot_q;
	logic [EW-1:0] ei_q, ec_q;
	logic [IW:0] clr_q;
	logic up_after_q;
	logic want_q;
	logic hold_v_q;
	logic [7:0] hold_id_q;

	logic he_we;
	logic [SW-1:0] he_wa, he_ra;
	logic [EW-1:0] he_wd, he_rd;
	logic so_we;
	logic [IW-1:0] so_wa, so_ra;
	logic [SW-1:0] so_wd, so_rd;
	logic pr_we, pr_wd, pr_rd;
	logic [IW-1:0] pr_wa;

	ith_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
		.clk, .we(he_we), .waddr(he_wa), .wdata(he_wd), .raddr(he_ra), .rdata(he_rd));
	ith_ram #(.WIDTH(SW), .DEPTH(ID_COUNT)) u_slot (
		.clk, .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
	ith_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_pres (
		.clk, .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(so_ra), .rdata(pr_rd));

	function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic state_t finish_state();
		return want_q ? S_EXPCHK : S_IDLE;
	endfunction

	logic [31:0] ei_exp, ec_exp, rd_exp, diff;
	logic id_ok;
	assign ei_exp = ei_q[31:0];
	assign ec_exp = ec_q[31:0];
	assign rd_exp = he_rd[31:0];
	assign diff = rd_exp - now_q;
	assign id_ok = ({24'd0, id_q} < 32'(ID_COUNT));
	assign so_ra = IW'(id_q);
	assign busy = (state_q != S_IDLE);

	// RAM write/read controls
	always_comb begin
		he_we = 1'b0; he_wa = i_q; he_wd = ei_q; he_ra = i_q;
		so_we = 1'b0; so_wa = IW'(id_q); so_wd = i_q;
		pr_we = 1'b0; pr_wa = IW'(id_q); pr_wd = 1'b0;
		case (state_q)
			S_CLEAR: begin
				pr_we = 1'b1; pr_wa = clr_q[IW-1:0];
			end
			S_SET: begin
				he_we = 1'b1; he_wa = i_q; he_wd = ei_q;
				so_we = 1'b1; so_wd = i_q;
				pr_we = 1'b1; pr_wd = 1'b1;
			end
			S_EXPCHK: he_ra = '0;
			S_REM: he_ra = SW'(count_q - CW'(1));
			S_REM2: begin
				pr_we = 1'b1; pr_wa = IW'(ei_q[39:32]);
				he_we = 1'b1; he_wa = rem_slot_q; he_wd = he_rd;
				so_we = 1'b1; so_wa = IW'(he_rd[39:32]); so_wd = rem_slot_q;
			end
			S_DN_RD: he_ra = i_q;
			S_DN_C1: he_ra = SW'(({1'b0, i_q} << 1) + 1);
			S_DN_C2: he_ra = SW'(({1'b0, i_q} << 1) + 2);
			S_UP_RD: he_ra = i_q;
			S_UP_P: he_ra = SW'((i_q - SW'(1)) >> 1);
			S_SWAP: begin
				he_we = 1'b1; he_wa = i_q; he_wd = ec_q;
				so_we = 1'b1; so_wa = IW'(ec_q[39:32]); so_wd = i_q;
			end
			S_SWAP2: begin
				he_we = 1'b1; he_wa = c_q; he_wd = ei_q;
				so_we = 1'b1; so_wa = IW'(ei_q[39:32]); so_wd = c_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			after_swap_q <= S_IDLE;
			clr_q <= '0;
			now_q <= '0;
			count_q <= '0;
			valid <= 1'b0;
			up_after_q <= 1'b0;
			want_q <= 1'b0;
			hold_v_q <= 1'b0;
			hold_id_q <= '0;
			kind_q <= '0; id_q <= '0; tmo_q <= '0;
			i_q <= '0; c_q <= '0; rem_slot_q <= '0;
			ei_q <= '0; ec_q <= '0;
			status <= '0; expired_id <= '0; remaining_ms <= '0;
			none_pending <= 1'b0; last <= 1'b0;
		end else begin
			if (state_q != S_DISPATCH && state_q != S_EXPCHK2) valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (IW+1)'(ID_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						kind_q <= kind; id_q <= timer_id; tmo_q <= timeout_ms;
						want_q <= 1'b0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_LOOK2;
				S_LOOK2: state_q <= S_DISPATCH;
				S_DISPATCH: begin
					case (kind_q)
						ith_pkg::KIND_ADD, ith_pkg::KIND_ADJUST: begin
							if (!id_ok) begin
								valid <= 1'b1; status <= ith_pkg::ST_UNKNOWN;
								expired_id <= id_q; remaining_ms <= '0;
								none_pending <= 1'b0; last <= 1'b1;
								state_q <= S_IDLE;
							end else if (pr_rd) begin
								valid <= 1'b0;
								i_q <= so_rd;
								ei_q <= {id_q, now_q + {8'd0, tmo_q}};
								up_after_q <= 1'b1;
								state_q <= S_SET;
							end else if (kind_q == ith_pkg::KIND_ADJUST) begin
								valid <= 1'b1; status <= ith_pkg::ST_UNKNOWN;
								expired_id <= id_q; remaining_ms <= '0;
								none_pending <= 1'b0; last <= 1'b1;
								state_q <= S_IDLE;
							end else if (count_q >= CW'(CAPACITY)) begin
								valid <= 1'b1; status <= ith_pkg::ST_FULL;
								expired_id <= id_q; remaining_ms <= '0;
								none_pending <= 1'b0; last <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								valid <= 1'b0;
								i_q <= SW'(count_q);
								ei_q <= {id_q, now_q + {8'd0, tmo_q}};
								count_q <= count_q + 1'b1;
								up_after_q <= 1'b0;
								state_q <= S_SET;
							end
						end
						ith_pkg::KIND_FIRE: begin
							if (!id_ok) begin
								valid <= 1'b1; status <= ith_pkg::ST_UNKNOWN;
								expired_id <= id_q; remaining_ms <= '0;
								none_pending <= 1'b0; last <= 1'b1;
								state_q <= S_IDLE;
							end else if (pr_rd && ({1'b0, so_rd} < (SW+1)'(count_q))) begin
								valid <= 1'b1; status <= ith_pkg::ST_FIRED;
								expired_id <= id_q; remaining_ms <= '0;
								none_pending <= 1'b0; last <= 1'b1;
								rem_slot_q <= so_rd;
								ei_q <= {id_q, 32'd0};
								want_q <= 1'b0;
								state_q <= S_REM;
							end else begin
								valid <= 1'b0;
								state_q <= S_IDLE;
							end
						end
						ith_pkg::KIND_TICK: begin
							valid <= 1'b0;
							now_q <= now_q + 1'b1;
							state_q <= S_EXPCHK;
						end
						ith_pkg::KIND_QUERY: begin
							valid <= 1'b0;
							state_q <= S_EXPCHK;
						end
						default: begin
							valid <= 1'b0;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SET: begin
					// sift up a new tail entry, sift down and then up a rearmed one
					state_q <= up_after_q ? S_DN_RD : S_UP_RD;
				end
				S_EXPCHK: state_q <= S_EXPCHK2;
				S_EXPCHK2: begin
					if (count_q != '0 && (diff == '0 || diff[31])) begin
						if (kind_q == ith_pkg::KIND_TICK) begin
							valid <= hold_v_q;
							expired_id <= hold_id_q;
							hold_v_q <= 1'b1;
							hold_id_q <= he_rd[39:32];
						end else begin
							valid <= 1'b1;
							expired_id <= he_rd[39:32];
						end
						status <= ith_pkg::ST_EXPIRED; remaining_ms <= '0;
						none_pending <= 1'b0; last <= 1'b0;
						ei_q <= {he_rd[39:32], 32'd0};
						rem_slot_q <= '0;
						want_q <= 1'b1;
						state_q <= S_REM;
					end else if (kind_q == ith_pkg::KIND_QUERY) begin
						valid <= 1'b1; status <= ith_pkg::ST_NEXT;
						expired_id <= '0; last <= 1'b1;
						none_pending <= (count_q == '0);
						remaining_ms <= (count_q == '0) ? '0 : diff[23:0];
						state_q <= S_IDLE;
					end else begin
						// release the held beat as the final one
						valid <= hold_v_q; status <= ith_pkg::ST_EXPIRED;
						expired_id <= hold_id_q; remaining_ms <= '0;
						none_pending <= 1'b0; last <= 1'b1;
						hold_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_REM: state_q <= S_REM2;
				S_REM2: begin
					count_q <= count_q - 1'b1;
					i_q <= rem_slot_q;
					if ({1'b0, rem_slot_q} < (SW+1)'(count_q - 1'b1)) begin
						up_after_q <= 1'b1;
						state_q <= S_DN_RD;
					end else begin
						state_q <= want_q ? S_EXPCHK : S_IDLE;
					end
				end
				S_DN_RD: state_q <= S_DN_C1;
				S_DN_C1: begin
					ei_q <= he_rd;
					if ((({1'b0, i_q} << 1) + 1) >= (SW+1)'(count_q)) begin
						state_q <= up_after_q ? S_UP_RD : finish_state();
					end else begin
						c_q <= SW'(({1'b0, i_q} << 1) + 1);
						state_q <= S_DN_C2;
					end
				end
				S_DN_C2: begin
					ec_q <= he_rd;
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					// he_rd holds child2 when it exists
					if ((({1'b0, i_q} << 1) + 2) < (SW+1)'(count_q) &&
					    !earlier(ec_exp, rd_exp)) begin
						ec_q <= he_rd;
						c_q <= SW'(({1'b0, i_q} << 1) + 2);
						if (earlier(rd_exp, ei_exp)) begin
							after_swap_q <= S_DN_RD;
							state_q <= S_SWAP;
						end else begin
							state_q <= up_after_q ? S_UP_RD : finish_state();
						end
					end else if (earlier(ec_exp, ei_exp)) begin
						after_swap_q <= S_DN_RD;
						state_q <= S_SWAP;
					end else begin
						state_q <= up_after_q ? S_UP_RD : finish_state();
					end
				end
				S_UP_RD: begin
					up_after_q <= 1'b0;
					if (i_q == '0 || {1'b0, i_q} >= (SW+1)'(count_q)) state_q <= finish_state();
					else state_q <= S_UP_P;
				end
				S_UP_P: begin
					ei_q <= he_rd;
					c_q <= SW'((i_q - SW'(1)) >> 1);
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					ec_q <= he_rd;
					if (earlier(ei_exp, rd_exp)) begin
						after_swap_q <= S_UP_RD;
						state_q <= S_SWAP;
					end else begin
						state_q <= finish_state();
					end
				end
				S_SWAP: state_q <= S_SWAP2;
				S_SWAP2: begin
					i_q <= c_q;
					state_q <= after_swap_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (status <= ith_pkg::ST_FULL));
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY));
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy);
	a_next_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status == ith_pkg::ST_NEXT) |-> last);
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && (status == ith_pkg::ST_FIRED || status == ith_pkg::ST_UNKNOWN ||
		status == ith_pkg::ST_FULL)) |-> last);

endmodule
